>>> sv/wpbc_pkg.sv
// shared constants and types for the window product below threshold counter
package wpbc_pkg;

    localparam int THRESH_WIDTH      = 32;
    localparam int COUNT_WIDTH       = 48;
    localparam int LEN_WIDTH         = 11;
    localparam int DEF_WINDOW_DEPTH  = 1024;
    localparam int DEF_VALUE_WIDTH   = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DROP_RD,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_INSERT,
        ST_CHECK,
        ST_FINISH
    } seq_state_t;

endpackage

>>> sv/wpbc_if.sv
// valid/ready channel interfaces for items, results and the threshold register

interface wpbc_in_if
    import wpbc_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
);
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] value;
    logic                   is_last;

    modport source (output valid, output value, output is_last, input ready);
    modport sink   (input valid, input value, input is_last, output ready);
endinterface

interface wpbc_out_if
    import wpbc_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [COUNT_WIDTH-1:0] running_count;
    logic [LEN_WIDTH-1:0]   window_length;
    logic                   overflow;
    logic                   done_res;

    modport source (output valid, output running_count, output window_length,
                    output overflow, output done_res, input ready);
    modport sink   (input valid, input running_count, input window_length,
                    input overflow, input done_res, output ready);
endinterface

interface wpbc_cfg_if
    import wpbc_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [THRESH_WIDTH-1:0] threshold;

    modport source (output valid, output threshold, input ready);
    modport sink   (input valid, input threshold, output ready);
endinterface

>>> sv/wpbc_store.sv
// ring store of window elements, one write port and one registered read port
module wpbc_store
    import wpbc_pkg::*;
#(
    parameter int DEPTH = DEF_WINDOW_DEPTH,
    parameter int WIDTH = DEF_VALUE_WIDTH,
    localparam int ADDR_W = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/wpbc_div.sv
// shared restoring divider, one quotient bit per cycle
module wpbc_div
    import wpbc_pkg::*;
#(
    parameter int DIVIDEND_W = THRESH_WIDTH + DEF_VALUE_WIDTH,
    parameter int DIVISOR_W  = DEF_VALUE_WIDTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dsr_reg, dsr_next;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    // one trial subtract per cycle
    always_comb
    begin
        trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff  = trial - {1'b0, dsr_reg};
        fits  = (trial >= {1'b0, dsr_reg});

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_W);
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            rem_next = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> sv/window_product_below_threshold_count.sv
// top level: sliding window product counter with sequencer, ring store and divider
//
//  channel | role   | transfer carries
//  --------+--------+--------------------------------------------------------
//  item    | sink   | value, is_last
//  result  | source | running_count, window_length, overflow, done_res
//  cfg     | sink   | threshold (always ready)
//
// an item passes through the insert, check and finish steps, plus a drop for every
// element removed while shrinking and for an eviction from a full ring;
// each drop is one pass through the bit-serial divider
// a threshold of one or less goes straight to the finish step and empties the window
// the result sits in an output register; the next item is taken while it waits
// the finish step holds only while an earlier result has not been transferred
// reset clears the window, the count and the threshold; the store needs no clearing
module window_product_below_threshold_count
    import wpbc_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
    parameter int VALUE_WIDTH  = DEF_VALUE_WIDTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    wpbc_in_if.sink    item,
    wpbc_out_if.source result,
    wpbc_cfg_if.sink   cfg
);

    localparam int PW    = THRESH_WIDTH + VALUE_WIDTH;
    localparam int PTR_W = $clog2(WINDOW_DEPTH);
    localparam int OCC_W = $clog2(WINDOW_DEPTH + 1);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    seq_state_t              state_reg, state_next;
    logic [THRESH_WIDTH-1:0] thr_reg;
    logic [PW-1:0]           prod_reg, prod_next;
    logic [PTR_W-1:0]        oldest_reg, oldest_next;
    logic [PTR_W-1:0]        newest_reg, newest_next;
    logic [OCC_W-1:0]        occ_reg, occ_next;
    logic [COUNT_WIDTH-1:0]  total_reg, total_next;
    logic [VALUE_WIDTH-1:0]  val_reg, val_next;
    logic                    last_reg, last_next;
    logic                    evict_reg, evict_next;
    logic                    ovf_reg, ovf_next;

    logic                    out_valid_reg, out_valid_next;
    logic [COUNT_WIDTH-1:0]  out_count_reg, out_count_next;
    logic [LEN_WIDTH-1:0]    out_len_reg, out_len_next;
    logic                    out_ovf_reg, out_ovf_next;
    logic                    out_done_reg, out_done_next;

    logic                    wr_en;
    logic [VALUE_WIDTH-1:0]  rd_data;
    logic                    div_start;
    logic                    div_done;
    logic [PW-1:0]           quotient;
    logic [PW-1:0]           mul_res;
    logic [VALUE_WIDTH-1:0]  in_value;
    logic [COUNT_WIDTH:0]    sum;
    logic [OCC_W+LEN_WIDTH-1:0] occ_wide;

    // ring store of window elements
    wpbc_store #(
        .DEPTH (WINDOW_DEPTH),
        .WIDTH (VALUE_WIDTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (newest_reg),
        .wr_data (val_reg),
        .rd_addr (oldest_reg),
        .rd_data (rd_data)
    );

    // shared divider for removing the oldest element from the product
    wpbc_div #(
        .DIVIDEND_W (PW),
        .DIVISOR_W  (VALUE_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (rd_data),
        .done     (div_done),
        .quotient (quotient)
    );

    // threshold register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= '0;
        end
        else if (cfg.valid)
        begin
            thr_reg <= cfg.threshold;
        end
    end

    // datapath helpers
    assign in_value = item.value[VALUE_WIDTH-1:0];
    assign mul_res  = PW'(prod_reg[THRESH_WIDTH-1:0]) * PW'(val_reg);
    assign sum      = {1'b0, total_reg} + (COUNT_WIDTH + 1)'(occ_reg);
    assign occ_wide = {{LEN_WIDTH{1'b0}}, occ_reg};

    assign item.ready = (state_reg == ST_IDLE);

    // sequencer: next state and datapath updates
    always_comb
    begin
        state_next     = state_reg;
        prod_next      = prod_reg;
        oldest_next    = oldest_reg;
        newest_next    = newest_reg;
        occ_next       = occ_reg;
        total_next     = total_reg;
        val_next       = val_reg;
        last_next      = last_reg;
        evict_next     = evict_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg & ~result.ready;
        out_count_next = out_count_reg;
        out_len_next   = out_len_reg;
        out_ovf_next   = out_ovf_reg;
        out_done_next  = out_done_reg;
        wr_en          = 1'b0;
        div_start      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    val_next   = (in_value == '0) ? VALUE_WIDTH'(1) : in_value;
                    last_next  = item.is_last;
                    ovf_next   = 1'b0;
                    evict_next = 1'b0;
                    if (thr_reg <= THRESH_WIDTH'(1))
                    begin
                        // threshold too low: window emptied, count kept
                        prod_next   = PW'(1);
                        oldest_next = '0;
                        newest_next = '0;
                        occ_next    = '0;
                        state_next  = ST_FINISH;
                    end
                    else if (occ_reg == OCC_W'(WINDOW_DEPTH))
                    begin
                        // ring full: evict the oldest first
                        evict_next = 1'b1;
                        ovf_next   = 1'b1;
                        state_next = ST_DROP_RD;
                    end
                    else
                    begin
                        state_next = ST_INSERT;
                    end
                end
            end

            ST_DROP_RD:
            begin
                state_next = ST_DIV_START;
            end

            ST_DIV_START:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end

            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    prod_next   = (occ_reg == OCC_W'(1)) ? PW'(1) : quotient;
                    oldest_next = (oldest_reg == PTR_W'(WINDOW_DEPTH - 1)) ?
                                  '0 : oldest_reg + PTR_W'(1);
                    occ_next    = occ_reg - OCC_W'(1);
                    evict_next  = 1'b0;
                    state_next  = evict_reg ? ST_INSERT : ST_CHECK;
                end
            end

            ST_INSERT:
            begin
                wr_en       = 1'b1;
                newest_next = (newest_reg == PTR_W'(WINDOW_DEPTH - 1)) ?
                              '0 : newest_reg + PTR_W'(1);
                occ_next    = occ_reg + OCC_W'(1);
                prod_next   = mul_res;
                state_next  = ST_CHECK;
            end

            ST_CHECK:
            begin
                if (occ_reg != '0 && prod_reg >= PW'(thr_reg))
                begin
                    state_next = ST_DROP_RD;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    // saturating count update and result load
                    if (sum > {1'b0, COUNT_MAX})
                    begin
                        out_count_next = COUNT_MAX;
                        out_ovf_next   = 1'b1;
                        total_next     = COUNT_MAX;
                    end
                    else
                    begin
                        out_count_next = sum[COUNT_WIDTH-1:0];
                        out_ovf_next   = ovf_reg;
                        total_next     = sum[COUNT_WIDTH-1:0];
                    end
                    out_len_next   = occ_wide[LEN_WIDTH-1:0];
                    out_done_next  = last_reg;
                    out_valid_next = 1'b1;
                    if (last_reg)
                    begin
                        prod_next   = PW'(1);
                        oldest_next = '0;
                        newest_next = '0;
                        occ_next    = '0;
                        total_next  = '0;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and window state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            prod_reg      <= PW'(1);
            oldest_reg    <= '0;
            newest_reg    <= '0;
            occ_reg       <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prod_reg      <= prod_next;
            oldest_reg    <= oldest_next;
            newest_reg    <= newest_next;
            occ_reg       <= occ_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        val_reg       <= val_next;
        last_reg      <= last_next;
        evict_reg     <= evict_next;
        ovf_reg       <= ovf_next;
        out_count_reg <= out_count_next;
        out_len_reg   <= out_len_next;
        out_ovf_reg   <= out_ovf_next;
        out_done_reg  <= out_done_next;
    end

    // result channel
    assign result.valid         = out_valid_reg;
    assign result.running_count = out_count_reg;
    assign result.window_length = out_len_reg;
    assign result.overflow      = out_ovf_reg;
    assign result.done_res      = out_done_reg;

endmodule

>>> verif/window_product_below_threshold_count_test.sv
// self-checking testbench for the window product below threshold counter
module window_product_below_threshold_count_test;
    import wpbc_pkg::*;

    localparam int RING_DEPTH    = DEF_WINDOW_DEPTH;
    localparam int RING_AW       = $clog2(RING_DEPTH);
    localparam int VAL_W         = DEF_VALUE_WIDTH;
    localparam longint unsigned COUNT_SAT = (64'd1 << COUNT_WIDTH) - 64'd1;
    localparam int IDLE_LIMIT    = 200000;
    localparam int SETTLE_CYCLES = 16;
    localparam int ITEM_TARGET   = 1550;
    localparam int LONG_RUN      = 1040;
    localparam logic [THRESH_WIDTH-1:0] THRESH_MAX = '1;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             is_last;
    } item_t;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] running_count;
        logic [LEN_WIDTH-1:0]   window_length;
        logic                   overflow;
        logic                   done_res;
    } result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    wpbc_in_if #(.VALUE_WIDTH(VAL_W)) item_ch ();
    wpbc_out_if result_ch ();
    wpbc_cfg_if cfg_ch ();

    window_product_below_threshold_count #(
        .WINDOW_DEPTH (RING_DEPTH),
        .VALUE_WIDTH  (VAL_W)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predicted window state
    logic [THRESH_WIDTH-1:0] threshold_reg;
    longint unsigned         win_product;
    logic [VAL_W-1:0]        win_ring [RING_DEPTH];
    int unsigned             win_oldest;
    int unsigned             win_newest;
    int unsigned             win_len;
    longint unsigned         run_total;

    // traffic queues and bookkeeping
    item_t                   pending_items[$];
    result_t                 expected_results[$];
    logic [THRESH_WIDTH-1:0] pending_thresholds[$];
    result_t                 oldest_expected;
    int                      item_gap = 0;
    int                      result_stall = 0;
    bit                      item_quiet = 1'b0;
    bit                      result_quiet = 1'b0;
    int                      mismatches = 0;
    int                      items_sent = 0;

    function automatic void empty_window();
        win_product = 1;
        win_oldest  = 0;
        win_newest  = 0;
        win_len     = 0;
    endfunction

    function automatic void drop_oldest();
        logic [VAL_W-1:0] v;
        v = win_ring[win_oldest[RING_AW-1:0]];
        if (v != 0)
            win_product = win_product / v;
        win_oldest = (win_oldest + 1) % RING_DEPTH;
        win_len--;
        if (win_len == 0)
            win_product = 1;
    endfunction

    // one element through the window: insert, shrink, accumulate
    function automatic result_t window_step(logic [VAL_W-1:0] value, logic is_last);
        logic [VAL_W-1:0] v;
        logic             ovf;
        result_t          r;
        v   = (value == 0) ? VAL_W'(1) : value;
        ovf = 1'b0;
        if (threshold_reg <= 1)
            empty_window();
        else
        begin
            // full ring evicts its oldest entry first
            if (win_len >= RING_DEPTH)
            begin
                drop_oldest();
                ovf = 1'b1;
            end
            win_ring[win_newest[RING_AW-1:0]] = v;
            win_newest = (win_newest + 1) % RING_DEPTH;
            win_len++;
            win_product = win_product * v;
            while (win_len > 0 && win_product >= threshold_reg)
                drop_oldest();
            if (run_total + win_len > COUNT_SAT)
            begin
                run_total = COUNT_SAT;
                ovf = 1'b1;
            end
            else
                run_total = run_total + win_len;
        end
        r.running_count = run_total[COUNT_WIDTH-1:0];
        r.window_length = win_len[LEN_WIDTH-1:0];
        r.overflow      = ovf;
        r.done_res      = is_last;
        if (is_last)
        begin
            empty_window();
            run_total = 0;
        end
        return r;
    endfunction

    // mostly short gaps, a few long ones, none while quiet
    function automatic int draw_gap(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 70);
    endfunction

    // item driver: each item held until its transfer, then a random gap
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_ch.valid   <= 1'b0;
            item_ch.value   <= '0;
            item_ch.is_last <= 1'b0;
            item_gap = 0;
        end
        else if (!(item_ch.valid && !item_ch.ready))
        begin
            if (item_ch.valid)
            begin
                expected_results.push_back(
                    window_step(pending_items[0].value, pending_items[0].is_last));
                void'(pending_items.pop_front());
                item_gap = draw_gap(item_quiet);
                if ($urandom_range(0, 149) == 0)
                    item_quiet = !item_quiet;
            end
            if (item_gap > 0)
            begin
                item_gap--;
                item_ch.valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                item_ch.valid   <= 1'b1;
                item_ch.value   <= pending_items[0].value;
                item_ch.is_last <= pending_items[0].is_last;
            end
            else
                item_ch.valid <= 1'b0;
        end
    end

    // result monitor: random back-pressure, compare against oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            result_stall = 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transfer with no result pending");
                    mismatches++;
                end
                else
                begin
                    oldest_expected = expected_results.pop_front();
                    if (result_ch.running_count !== oldest_expected.running_count)
                    begin
                        $error("running_count: expected %0d, got %0d",
                               oldest_expected.running_count, result_ch.running_count);
                        mismatches++;
                    end
                    if (result_ch.window_length !== oldest_expected.window_length)
                    begin
                        $error("window_length: expected %0d, got %0d",
                               oldest_expected.window_length, result_ch.window_length);
                        mismatches++;
                    end
                    if (result_ch.overflow !== oldest_expected.overflow)
                    begin
                        $error("overflow: expected %0b, got %0b",
                               oldest_expected.overflow, result_ch.overflow);
                        mismatches++;
                    end
                    if (result_ch.done_res !== oldest_expected.done_res)
                    begin
                        $error("done_res: expected %0b, got %0b",
                               oldest_expected.done_res, result_ch.done_res);
                        mismatches++;
                    end
                end
                if ($urandom_range(0, 149) == 0)
                    result_quiet = !result_quiet;
            end
            if (result_stall == 0)
                result_stall = draw_gap(result_quiet);
            if (result_stall > 0)
            begin
                result_stall--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // threshold register writes, applied to the prediction on transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_ch.valid     <= 1'b0;
            cfg_ch.threshold <= '0;
        end
        else if (!(cfg_ch.valid && !cfg_ch.ready))
        begin
            if (cfg_ch.valid)
            begin
                threshold_reg = cfg_ch.threshold;
                void'(pending_thresholds.pop_front());
            end
            if (pending_thresholds.size() > 0)
            begin
                cfg_ch.valid     <= 1'b1;
                cfg_ch.threshold <= pending_thresholds[0];
            end
            else
                cfg_ch.valid <= 1'b0;
        end
    end

    // watchdog on cycles without any transfer
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("** window_product_below_threshold_count: FAILED **");
        $finish;
    end

    task automatic send(input logic [VAL_W-1:0] value, input logic is_last);
        item_t it;
        it.value   = value;
        it.is_last = is_last;
        pending_items.push_back(it);
        items_sent++;
    endtask

    // wait for every result, then let the block settle
    task automatic drain();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_threshold(input logic [THRESH_WIDTH-1:0] value);
        drain();
        pending_thresholds.push_back(value);
        do
            @(negedge clk);
        while (pending_thresholds.size() != 0);
    endtask

    // stimulus
    initial
    begin
        int                      seq_len;
        int                      r;
        logic [THRESH_WIDTH-1:0] thr;
        logic [VAL_W-1:0]        v;

        item_ch.valid    = 1'b0;
        item_ch.value    = '0;
        item_ch.is_last  = 1'b0;
        result_ch.ready  = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.threshold = '0;
        threshold_reg    = '0;
        run_total        = 0;
        empty_window();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // threshold left at its reset value: counts stay zero
        send(16'h0001, 1'b0);
        send(16'hFFFF, 1'b1);

        // threshold of one, zero value
        write_threshold(1);
        send(16'h8000, 1'b0);
        send(16'h0000, 1'b1);

        // smallest useful threshold, window emptied completely
        write_threshold(2);
        send(16'd1, 1'b0);
        send(16'd1, 1'b0);
        send(16'd2, 1'b1);

        // textbook case, zero taken as one
        write_threshold(100);
        send(16'd10, 1'b0);
        send(16'd5, 1'b0);
        send(16'd2, 1'b0);
        send(16'd6, 1'b0);
        send(16'd0, 1'b1);

        // largest values and threshold, then threshold lowered mid-sequence
        write_threshold(THRESH_MAX);
        send(16'hFFFF, 1'b0);
        send(16'hFFFF, 1'b0);
        send(16'hFFFF, 1'b0);
        write_threshold(3);
        send(16'd1, 1'b0);
        send(16'd1, 1'b1);

        // threshold raised mid-sequence
        write_threshold(50);
        send(16'd7, 1'b0);
        send(16'd7, 1'b0);
        write_threshold(1000);
        send(16'd7, 1'b0);
        send(16'd7, 1'b1);

        write_threshold(THRESH_MAX);
        send(16'hAAAA, 1'b0);
        send(16'h5555, 1'b1);

        // long run of small values fills the ring and forces evictions
        for (int k = 0; k < LONG_RUN; k++)
            send(($urandom_range(0, 63) == 0) ? 16'd2 : 16'd1, 1'b0);
        // then a low threshold empties the full window in one step
        write_threshold(2);
        send(16'd2, 1'b1);

        // random sequences, mostly closed by a last item
        while (items_sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                r = $urandom_range(0, 99);
                if (r < 6)
                    thr = $urandom_range(0, 1);
                else if (r < 12)
                    thr = THRESH_MAX;
                else if (r < 30)
                    thr = $urandom_range(2, 64);
                else if (r < 55)
                    thr = $urandom_range(65, 100000);
                else if (r < 80)
                    thr = $urandom_range(100001, 32'h0100_0000);
                else
                    thr = $urandom();
                write_threshold(thr);
            end
            seq_len = $urandom_range(1, 40);
            for (int k = 0; k < seq_len; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 3)
                    v = '0;
                else if (r < 25)
                    v = 16'd1;
                else if (r < 55)
                    v = VAL_W'($urandom_range(2, 15));
                else if (r < 75)
                    v = VAL_W'($urandom_range(16, 255));
                else
                    v = VAL_W'($urandom_range(0, 16'hFFFF));
                send(v, (k == seq_len - 1) && ($urandom_range(0, 99) < 85));
            end
        end

        drain();
        if (mismatches == 0)
            $display("** window_product_below_threshold_count: PASSED **");
        else
            $display("** window_product_below_threshold_count: FAILED **");
        $finish;
    end

endmodule
